// ===== rtl/core/mbru_pkg.sv =====
`timescale 1ns / 1ps

package mbru_pkg;

    // Bitmap geometry and upscale factor.
    localparam int LOGICAL_COLS = 120;
    localparam int LOGICAL_ROWS = 160;
    localparam int SCALE        = 2;

    // Store size and derived widths.
    localparam int STORE_BYTES = (LOGICAL_COLS * LOGICAL_ROWS + 7) / 8;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int PIX_W       = $clog2(LOGICAL_COLS * LOGICAL_ROWS);
    localparam int PHASE_W     = (SCALE > 1) ? $clog2(SCALE) : 1;

    // Field widths.
    localparam int OP_W      = 2;
    localparam int LADDR_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 16;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int WIN_CNT_W = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_COL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd3;

    localparam logic [VALUE_W-1:0] COLOR_ON = 16'hFFFF;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_WINDOW,
        ST_IDLE_RES
    } mbru_state_t;

    // Store write and read requests.
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } mbru_wr_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
    } mbru_rd_t;

endpackage

// ===== rtl/core/mbru_in_if.sv =====
`timescale 1ns / 1ps

interface mbru_in_if;
    logic                           valid;
    logic                           ready;
    logic [mbru_pkg::OP_W-1:0]      op;
    logic [mbru_pkg::LADDR_W-1:0]   load_address;
    logic [mbru_pkg::BYTE_W-1:0]    load_byte;

    modport source (output valid, output op, output load_address, output load_byte,
                    input ready);
    modport sink   (input valid, input op, input load_address, input load_byte,
                    output ready);
endinterface

// ===== rtl/core/mbru_out_if.sv =====
`timescale 1ns / 1ps

interface mbru_out_if;
    logic                           valid;
    logic                           ready;
    logic [mbru_pkg::KIND_W-1:0]    kind;
    logic [mbru_pkg::VALUE_W-1:0]   value;
    logic                           last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== rtl/core/mbru_cfg_if.sv =====
`timescale 1ns / 1ps

interface mbru_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mbru_pkg::CFG_IDX_W-1:0]   index;
    logic [mbru_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mbru_store.sv =====
`timescale 1ns / 1ps

module mbru_store (
    input  logic                          clk,
    input  mbru_pkg::mbru_wr_t            wr,
    input  mbru_pkg::mbru_rd_t            rd,
    output logic [mbru_pkg::BYTE_W-1:0]   rdata
);
    import mbru_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] rdata_reg;

    // Single write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mbru_seq.sv =====
`timescale 1ns / 1ps

module mbru_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    mbru_in_if.sink                       req,
    mbru_out_if.source                    rsp,
    mbru_cfg_if.sink                      cfg,
    output mbru_pkg::mbru_wr_t            wr,
    output mbru_pkg::mbru_rd_t            rd,
    input  logic [mbru_pkg::BYTE_W-1:0]   rdata
);
    import mbru_pkg::*;

    localparam logic [COL_W-1:0]     COL_MAX   = COL_W'(LOGICAL_COLS - 1);
    localparam logic [ROW_W-1:0]     ROW_MAX   = ROW_W'(LOGICAL_ROWS - 1);
    localparam logic [PHASE_W-1:0]   PHASE_MAX = PHASE_W'(SCALE - 1);
    localparam logic [WIN_CNT_W-1:0] WIN_LAST  = WIN_CNT_W'(7);

    mbru_state_t state_reg, state_next;

    logic [COL_W-1:0]     left_reg, right_reg;
    logic [ROW_W-1:0]     top_reg, bottom_reg;
    logic [COL_W-1:0]     draw_left_reg, draw_right_reg;
    logic [ROW_W-1:0]     draw_top_reg, draw_bottom_reg;
    logic [COL_W-1:0]     cursor_col_reg;
    logic [ROW_W-1:0]     cursor_row_reg;
    logic [PHASE_W-1:0]   col_phase_reg, row_phase_reg;
    logic                 active_reg;
    logic [WIN_CNT_W-1:0] win_cnt_reg;
    logic [2:0]           bit_sel_reg;

    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 out_free;
    logic [COL_W-1:0]     clamp_left, clamp_right;
    logic [ROW_W-1:0]     clamp_top, clamp_bottom;
    logic [PIX_W-1:0]     pix_idx;
    logic [VALUE_W-1:0]   px0, px1, py0, py1;
    logic                 col_end, row_end, is_last;
    logic                 emit;
    logic [KIND_W-1:0]    emit_kind;
    logic [VALUE_W-1:0]   emit_value;
    logic                 emit_last;

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Region clamped to the bitmap.
    assign clamp_left   = (left_reg   > COL_MAX) ? COL_MAX : left_reg;
    assign clamp_right  = (right_reg  > COL_MAX) ? COL_MAX : right_reg;
    assign clamp_top    = (top_reg    > ROW_MAX) ? ROW_MAX : top_reg;
    assign clamp_bottom = (bottom_reg > ROW_MAX) ? ROW_MAX : bottom_reg;

    // Pixel index of the cursor and the store requests.
    assign pix_idx = PIX_W'(cursor_row_reg) * PIX_W'(LOGICAL_COLS) + PIX_W'(cursor_col_reg);

    always_comb
    begin
        wr.en   = accept && (req.op == OP_LOAD) &&
                  (req.load_address < LADDR_W'(STORE_BYTES));
        wr.addr = req.load_address[STORE_AW-1:0];
        wr.data = req.load_byte;
        rd.en   = accept && (req.op == OP_NEXT) && active_reg;
        rd.addr = STORE_AW'(pix_idx >> 3);
    end

    // Physical window from the latched region.
    assign px0 = VALUE_W'(draw_left_reg) * VALUE_W'(SCALE);
    assign px1 = (VALUE_W'(draw_right_reg) + VALUE_W'(1)) * VALUE_W'(SCALE) - VALUE_W'(1);
    assign py0 = VALUE_W'(draw_top_reg) * VALUE_W'(SCALE);
    assign py1 = (VALUE_W'(draw_bottom_reg) + VALUE_W'(1)) * VALUE_W'(SCALE) - VALUE_W'(1);

    // End of column run, row run and whole region.
    assign col_end = (cursor_col_reg == draw_right_reg) && (col_phase_reg == PHASE_MAX);
    assign row_end = (row_phase_reg == PHASE_MAX);
    assign is_last = col_end && row_end && (cursor_row_reg == draw_bottom_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (req.op == OP_START)
                        state_next = ST_WINDOW;
                    else if (req.op == OP_NEXT)
                        state_next = active_reg ? ST_PIXEL : ST_IDLE_RES;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_WINDOW:
            begin
                if (out_free && (win_cnt_reg == WIN_LAST))
                    state_next = ST_IDLE;
            end
            ST_PIXEL, ST_IDLE_RES:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result to load into the output register.
    always_comb
    begin
        emit       = 1'b0;
        emit_kind  = KIND_IDLE;
        emit_value = '0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_WINDOW:
            begin
                emit      = out_free;
                emit_kind = win_cnt_reg[2] ? KIND_ROW : KIND_COL;
                emit_last = (win_cnt_reg == WIN_LAST);
                unique case (win_cnt_reg)
                    3'd0:    emit_value = VALUE_W'(px0[15:8]);
                    3'd1:    emit_value = VALUE_W'(px0[7:0]);
                    3'd2:    emit_value = VALUE_W'(px1[15:8]);
                    3'd3:    emit_value = VALUE_W'(px1[7:0]);
                    3'd4:    emit_value = VALUE_W'(py0[15:8]);
                    3'd5:    emit_value = VALUE_W'(py0[7:0]);
                    3'd6:    emit_value = VALUE_W'(py1[15:8]);
                    default: emit_value = VALUE_W'(py1[7:0]);
                endcase
            end
            ST_PIXEL:
            begin
                emit       = out_free;
                emit_kind  = KIND_PIXEL;
                emit_value = rdata[3'd7 - bit_sel_reg] ? COLOR_ON : '0;
                emit_last  = is_last;
            end
            ST_IDLE_RES:
            begin
                emit = out_free;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Region registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= COL_W'(119);
            bottom_reg <= ROW_W'(159);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_LEFT:   left_reg   <= cfg.data[COL_W-1:0];
                REG_TOP:    top_reg    <= cfg.data[ROW_W-1:0];
                REG_RIGHT:  right_reg  <= cfg.data[COL_W-1:0];
                REG_BOTTOM: bottom_reg <= cfg.data[ROW_W-1:0];
                default:    left_reg   <= left_reg;
            endcase
        end
    end

    // Draw state: latched region, cursor and repeat phases.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_left_reg   <= '0;
            draw_right_reg  <= '0;
            draw_top_reg    <= '0;
            draw_bottom_reg <= '0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            col_phase_reg   <= '0;
            row_phase_reg   <= '0;
            active_reg      <= 1'b0;
            win_cnt_reg     <= '0;
            bit_sel_reg     <= '0;
        end
        else
        begin
            if (accept && (req.op == OP_START))
            begin
                draw_left_reg   <= clamp_left;
                draw_right_reg  <= clamp_right;
                draw_top_reg    <= clamp_top;
                draw_bottom_reg <= clamp_bottom;
                cursor_col_reg  <= clamp_left;
                cursor_row_reg  <= clamp_top;
                col_phase_reg   <= '0;
                row_phase_reg   <= '0;
                active_reg      <= (clamp_left <= clamp_right) && (clamp_top <= clamp_bottom);
                win_cnt_reg     <= '0;
            end
            if (rd.en)
            begin
                bit_sel_reg <= pix_idx[2:0];
            end
            if (emit && (state_reg == ST_WINDOW))
            begin
                win_cnt_reg <= win_cnt_reg + WIN_CNT_W'(1);
            end
            if (emit && (state_reg == ST_PIXEL))
            begin
                priority if (is_last)
                begin
                    active_reg     <= 1'b0;
                    cursor_col_reg <= '0;
                    cursor_row_reg <= '0;
                    col_phase_reg  <= '0;
                    row_phase_reg  <= '0;
                end
                else if (col_phase_reg != PHASE_MAX)
                begin
                    col_phase_reg <= col_phase_reg + PHASE_W'(1);
                end
                else
                begin
                    col_phase_reg <= '0;
                    if (cursor_col_reg < draw_right_reg)
                    begin
                        cursor_col_reg <= cursor_col_reg + COL_W'(1);
                    end
                    else
                    begin
                        cursor_col_reg <= draw_left_reg;
                        if (row_phase_reg != PHASE_MAX)
                        begin
                            row_phase_reg <= row_phase_reg + PHASE_W'(1);
                        end
                        else
                        begin
                            row_phase_reg  <= '0;
                            cursor_row_reg <= cursor_row_reg + ROW_W'(1);
                        end
                    end
                end
            end
        end
    end

    // Output register: holds one result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_last_reg  <= emit_last;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.kind  = out_kind_reg;
    assign rsp.value = out_value_reg;
    assign rsp.last  = out_last_reg;

endmodule

// ===== rtl/core/mono_bitmap_region_upscaler.sv =====
`timescale 1ns / 1ps

// Monochrome bitmap region upscaler. A 120 by 160 one-bit bitmap (2400 bytes, row-major,
// most significant bit leftmost) is filled by load items and read back as RGB565 pixels,
// each logical pixel repeated twice across and twice down. A start item latches the
// region registers, clamped to the bitmap, and returns the eight window bytes; each next
// item returns one physical pixel, with last set on the final one, or an idle result when
// no draw is active. A next item makes a registered read of the bitmap memory and then
// loads the output register; a start item, once accepted, sends one window byte a cycle
// from the output register while the output is not stalled. A result waiting at the output
// stalls the next item that has a result and every item behind it. The bitmap memory
// is not cleared at reset; a byte must be loaded before a draw reads it. Region registers
// are to be written only while the block is idle.
module mono_bitmap_region_upscaler (
    input  logic         clk,
    input  logic         rst_n,
    mbru_in_if.sink      req,
    mbru_out_if.source   rsp,
    mbru_cfg_if.sink     cfg
);
    import mbru_pkg::*;

    mbru_wr_t          wr;
    mbru_rd_t          rd;
    logic [BYTE_W-1:0] rdata;

    // Sequencer: decodes items, walks the region and drives the results.
    mbru_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    // Bitmap memory.
    mbru_store u_store (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

endmodule

// ===== rtl/core/mbru_checker.sv =====
`timescale 1ns / 1ps

module mbru_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [mbru_pkg::KIND_W-1:0]   rsp_kind,
    input logic [mbru_pkg::VALUE_W-1:0]  rsp_value,
    input logic                          rsp_last
);
    import mbru_pkg::*;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
        $stable(rsp_value) && $stable(rsp_last))
    else $error("result changed while stalled");

    // An idle result carries nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_IDLE) |-> (rsp_value == '0) && !rsp_last)
    else $error("idle result with payload");

    // A pixel is fully white or fully black.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_PIXEL) |-> (rsp_value == COLOR_ON) ||
        (rsp_value == '0))
    else $error("pixel colour out of range");

    // Window results are single bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_kind == KIND_COL) || (rsp_kind == KIND_ROW)) |->
        (rsp_value[15:8] == 8'h00))
    else $error("window byte wider than eight bits");

endmodule

bind mono_bitmap_region_upscaler mbru_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_value (rsp.value),
    .rsp_last  (rsp.last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mbru_pkg::*;

    // Unused operation code, which the block must swallow without a result.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Settling wait after the last result, to cover any tail.
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 200;
    localparam int QUIET_LIMIT    = 2000;
    localparam int MAX_PRINTED    = 50;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 30;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LADDR_W-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } upscaler_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } upscaler_out_t;

    // Region registers, the region latched at start and the draw cursor.
    typedef struct packed {
        logic [COL_W-1:0] reg_left;
        logic [COL_W-1:0] reg_right;
        logic [ROW_W-1:0] reg_top;
        logic [ROW_W-1:0] reg_bottom;
        logic [COL_W-1:0] win_left;
        logic [COL_W-1:0] win_right;
        logic [ROW_W-1:0] win_top;
        logic [ROW_W-1:0] win_bottom;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        int unsigned      col_rep;
        int unsigned      row_rep;
        logic             active;
    } draw_state_t;

    logic clk = 1'b0;
    logic rst_n;

    mbru_in_if  cmd_ch ();
    mbru_out_if out_ch ();
    mbru_cfg_if cfg_ch ();

    mono_bitmap_region_upscaler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (out_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // Bitmap contents as the block should hold them once items are accepted.
    bit [BYTE_W-1:0] bitmap_bytes [STORE_BYTES];
    // Bytes for which a load has already been queued.
    bit              byte_loaded [STORE_BYTES];

    draw_state_t     model_state;
    draw_state_t     plan_state;
    upscaler_out_t   step_results [8];
    upscaler_out_t   due_outputs [$];
    upscaler_cmd_t   queued_cmds [$];

    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    logic cmd_taken      = 1'b0;
    int   send_gap       = 0;
    int   send_calm      = 0;
    int   ready_hold     = 0;
    int   ready_calm     = 0;
    logic long_hold_ask  = 1'b0;
    logic long_hold_done = 1'b0;

    function automatic draw_state_t reset_state();
        draw_state_t s;
        s = '0;
        s.reg_right  = COL_W'(LOGICAL_COLS - 1);
        s.reg_bottom = ROW_W'(LOGICAL_ROWS - 1);
        return s;
    endfunction

    function automatic void apply_reg(inout draw_state_t s, input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] d);
        case (idx)
            REG_LEFT:   s.reg_left   = d[COL_W-1:0];
            REG_TOP:    s.reg_top    = d[ROW_W-1:0];
            REG_RIGHT:  s.reg_right  = d[COL_W-1:0];
            REG_BOTTOM: s.reg_bottom = d[ROW_W-1:0];
            default:    ;
        endcase
    endfunction

    function automatic upscaler_out_t make_out(input logic [KIND_W-1:0] kind,
                                               input int unsigned v, input logic last);
        upscaler_out_t o;
        o.kind  = kind;
        o.value = VALUE_W'(v);
        o.last  = last;
        return o;
    endfunction

    // Works out the results of one item into step_results and returns their number.
    // rd_byte gives the store byte that a pixel reads, or -1.
    function automatic int upscale_step(inout draw_state_t s, input upscaler_cmd_t c,
                                        output int rd_byte);
        int unsigned l, t, r, b;
        int unsigned px0, px1, py0, py1;
        int unsigned idx;
        logic        lit;
        logic        final_px;
        rd_byte = -1;
        upscale_step = 0;
        case (c.op)
            OP_LOAD:
            begin
                if (c.addr < STORE_BYTES)
                    bitmap_bytes[c.addr] = c.data;
            end
            OP_START:
            begin
                // Registers beyond the bitmap are clamped to its last column or row.
                l = (s.reg_left   < LOGICAL_COLS) ? s.reg_left   : LOGICAL_COLS - 1;
                r = (s.reg_right  < LOGICAL_COLS) ? s.reg_right  : LOGICAL_COLS - 1;
                t = (s.reg_top    < LOGICAL_ROWS) ? s.reg_top    : LOGICAL_ROWS - 1;
                b = (s.reg_bottom < LOGICAL_ROWS) ? s.reg_bottom : LOGICAL_ROWS - 1;
                px0 = l * SCALE;
                px1 = (r + 1) * SCALE - 1;
                py0 = t * SCALE;
                py1 = (b + 1) * SCALE - 1;
                step_results[0] = make_out(KIND_COL, (px0 >> 8) & 'hFF, 1'b0);
                step_results[1] = make_out(KIND_COL, px0 & 'hFF, 1'b0);
                step_results[2] = make_out(KIND_COL, (px1 >> 8) & 'hFF, 1'b0);
                step_results[3] = make_out(KIND_COL, px1 & 'hFF, 1'b0);
                step_results[4] = make_out(KIND_ROW, (py0 >> 8) & 'hFF, 1'b0);
                step_results[5] = make_out(KIND_ROW, py0 & 'hFF, 1'b0);
                step_results[6] = make_out(KIND_ROW, (py1 >> 8) & 'hFF, 1'b0);
                step_results[7] = make_out(KIND_ROW, py1 & 'hFF, 1'b1);
                s.win_left   = COL_W'(l);
                s.win_right  = COL_W'(r);
                s.win_top    = ROW_W'(t);
                s.win_bottom = ROW_W'(b);
                s.col        = COL_W'(l);
                s.row        = ROW_W'(t);
                s.col_rep    = 0;
                s.row_rep    = 0;
                // An empty region still sends its window but starts no draw.
                s.active     = (l <= r) && (t <= b);
                upscale_step = 8;
            end
            OP_NEXT:
            begin
                upscale_step = 1;
                if (!s.active)
                    step_results[0] = make_out(KIND_IDLE, 0, 1'b0);
                else
                begin
                    idx      = s.row * LOGICAL_COLS + s.col;
                    rd_byte  = int'(idx >> 3);
                    lit      = bitmap_bytes[rd_byte][7 - (idx % 8)];
                    final_px = (s.col == s.win_right) && (s.col_rep == SCALE - 1) &&
                               (s.row_rep == SCALE - 1) && (s.row == s.win_bottom);
                    step_results[0] = make_out(KIND_PIXEL, lit ? COLOR_ON : 0, final_px);
                    // Column repeat runs fastest, then column, then row repeat, then row.
                    if (final_px)
                    begin
                        s.active  = 1'b0;
                        s.col     = '0;
                        s.row     = '0;
                        s.col_rep = 0;
                        s.row_rep = 0;
                    end
                    else if (s.col_rep < SCALE - 1)
                        s.col_rep = s.col_rep + 1;
                    else
                    begin
                        s.col_rep = 0;
                        if (s.col < s.win_right)
                            s.col = s.col + 1'b1;
                        else
                        begin
                            s.col = s.win_left;
                            if (s.row_rep < SCALE - 1)
                                s.row_rep = s.row_rep + 1;
                            else
                            begin
                                s.row_rep = 0;
                                s.row     = s.row + 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm run with none.
    function automatic int pick_gap(inout int calm_left);
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: %s: got %0h, wanted %0h", $time, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Queues an item. A pixel that would read a byte not yet loaded gets a load first,
    // so the store is never read where it was not written.
    task automatic queue_cmd(input logic [OP_W-1:0] op, input int unsigned addr,
                             input int unsigned data);
        upscaler_cmd_t c;
        upscaler_cmd_t fill;
        draw_state_t   probe;
        int            rd;
        c.op   = op;
        c.addr = LADDR_W'(addr);
        c.data = BYTE_W'(data);
        if (op == OP_LOAD)
        begin
            if (c.addr < STORE_BYTES)
                byte_loaded[c.addr] = 1'b1;
        end
        else
        begin
            // Loads are left out here: the bitmap copy changes only on acceptance.
            probe = plan_state;
            void'(upscale_step(probe, c, rd));
            if (rd >= 0 && !byte_loaded[rd])
            begin
                fill.op   = OP_LOAD;
                fill.addr = LADDR_W'(rd);
                fill.data = BYTE_W'($urandom);
                queued_cmds.push_back(fill);
                byte_loaded[rd] = 1'b1;
            end
            plan_state = probe;
        end
        queued_cmds.push_back(c);
    endtask

    task automatic write_region_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(model_state, idx, d);
        apply_reg(plan_state, idx, d);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Column registers get a random top bit, which the block must ignore.
    task automatic write_region(input int unsigned l, input int unsigned t,
                                input int unsigned r, input int unsigned b);
        write_region_reg(REG_LEFT,   {1'($urandom), 7'(l)});
        write_region_reg(REG_TOP,    8'(t));
        write_region_reg(REG_RIGHT,  {1'($urandom), 7'(r)});
        write_region_reg(REG_BOTTOM, 8'(b));
    endtask

    task automatic write_random_region();
        int unsigned pick, l, t;
        pick = $urandom_range(0, 9);
        l = $urandom_range(1, LOGICAL_COLS - 1);
        t = $urandom_range(1, LOGICAL_ROWS - 1);
        case (pick)
            0: write_region(l, t, $urandom_range(0, l - 1), t + $urandom_range(0, 1));
            1: write_region(l, t, l + $urandom_range(0, 3), $urandom_range(0, t - 1));
            2: write_region($urandom_range(100, 127), $urandom_range(140, 255),
                            $urandom_range(110, 127), $urandom_range(150, 255));
            3: write_region($urandom_range(0, 2), t, $urandom_range(117, 119), t);
            default: write_region(l - 1, t - 1, l - 1 + $urandom_range(0, 3),
                                  t - 1 + $urandom_range(0, 1));
        endcase
    endtask

    // Mostly complete draws with the odd restart, idle pixel and ignored item.
    task automatic queue_random_phase(input int budget);
        int          counted;
        int unsigned sel;
        int unsigned addr;
        counted = 0;
        while (counted < budget)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                queue_cmd(OP_SPARE, $urandom_range(0, 4095), $urandom_range(0, 255));
            else if (sel == 1)
            begin
                addr = $urandom_range(0, 4095);
                queue_cmd(OP_LOAD, addr, $urandom_range(0, 255));
                if (addr < STORE_BYTES)
                    counted = counted + 1;
            end
            else if (sel == 2 || (!plan_state.active && sel < 16))
            begin
                queue_cmd(OP_START, $urandom_range(0, 4095), $urandom_range(0, 255));
                counted = counted + 1;
            end
            else
            begin
                queue_cmd(OP_NEXT, $urandom_range(0, 4095), $urandom_range(0, 255));
                counted = counted + 1;
            end
        end
    endtask

    // Holds off until every item is sent and every result has come, then lets the
    // block settle.
    task automatic wait_idle();
        while (queued_cmds.size() != 0 || cmd_ch.valid || due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Item driver: presents the next queued item after its gap.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_ch.valid || cmd_taken))
        begin
            if (send_gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (queued_cmds.size() != 0)
            begin
                cmd_ch.valid        <= 1'b1;
                cmd_ch.op           <= queued_cmds[0].op;
                cmd_ch.load_address <= queued_cmds[0].addr;
                cmd_ch.load_byte    <= queued_cmds[0].data;
                void'(queued_cmds.pop_front());
                send_gap <= pick_gap(send_calm);
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, and one long hold while items keep coming.
    always @(negedge clk)
    begin
        if (long_hold_ask && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            ready_hold     <= LONG_HOLD;
            out_ch.ready   <= 1'b0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold   <= ready_hold - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            ready_hold   <= pick_gap(ready_calm);
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: checks each result first, then predicts for an item taken at this edge.
    always @(posedge clk)
    begin
        upscaler_out_t want;
        int            n;
        int            rd;
        cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_outputs.size() == 0)
                    note_mismatch("result with nothing due, kind", out_ch.kind, -1);
                else
                begin
                    want = due_outputs.pop_front();
                    if (out_ch.kind !== want.kind)
                        note_mismatch("kind", out_ch.kind, want.kind);
                    if (out_ch.value !== want.value)
                        note_mismatch("value", out_ch.value, want.value);
                    if (out_ch.last !== want.last)
                        note_mismatch("last", out_ch.last, want.last);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                n = upscale_step(model_state,
                                 {cmd_ch.op, cmd_ch.load_address, cmd_ch.load_byte}, rd);
                for (int i = 0; i < n; i++)
                    due_outputs.push_back(step_results[i]);
            end
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("mono_bitmap_region_upscaler: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.op           = OP_LOAD;
        cmd_ch.load_address = '0;
        cmd_ch.load_byte    = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_LEFT;
        cfg_ch.data         = '0;
        model_state         = reset_state();
        plan_state          = reset_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset region: idle pixel, ignored items, then the whole bitmap as the region.
        queue_cmd(OP_NEXT, 0, 0);
        queue_cmd(OP_SPARE, 4095, 255);
        queue_cmd(OP_LOAD, 4095, 255);
        queue_cmd(OP_LOAD, STORE_BYTES, 0);
        queue_cmd(OP_LOAD, 0, 'hA5);
        queue_cmd(OP_LOAD, 15, 'h3C);
        queue_cmd(OP_START, 0, 0);
        repeat (5) queue_cmd(OP_NEXT, 4095, 255);
        wait_idle();

        // Registers beyond the bitmap clamp to the last pixel; the old draw runs on
        // with its latched region before the new start.
        write_region(127, 255, 127, 160);
        repeat (3) queue_cmd(OP_NEXT, 0, 0);
        queue_cmd(OP_LOAD, STORE_BYTES - 1, 'h01);
        queue_cmd(OP_START, 0, 0);
        repeat (5) queue_cmd(OP_NEXT, 0, 0);
        wait_idle();

        // Empty regions, first across and then down.
        write_region(5, 0, 3, 0);
        queue_cmd(OP_START, 0, 0);
        queue_cmd(OP_NEXT, 0, 0);
        wait_idle();
        write_region(0, 9, 0, 2);
        queue_cmd(OP_START, 0, 0);
        queue_cmd(OP_NEXT, 0, 0);
        wait_idle();

        // Random phases, each under a fresh region setting.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_random_region();
            queue_random_phase(ITEMS_PER_PHASE);
            if (p == 1)
                long_hold_ask = 1'b1;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("mono_bitmap_region_upscaler: match");
        else
            $display("mono_bitmap_region_upscaler: mismatch");
        $finish;
    end

endmodule
